/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the fader RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked on every clock edge outside reset.
`define MCVF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define MCVF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

/* hw/rtl/mcvf_pkg.sv */
// Shared constants, codes and structs of the multichannel volume fader.
package mcvf_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int MAX_VOLUME   = 100;
  localparam int FRAC_BITS    = 16;

  localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int TGT_W     = (MAX_VOLUME > 1) ? $clog2(MAX_VOLUME + 1) : 1;
  localparam int LVL_W     = TGT_W + FRAC_BITS;
  localparam int STEP_W    = LVL_W + 1;
  localparam int FR_W      = 16;
  localparam int KIND_W    = 3;
  localparam int CHAN_IO_W = 3;
  localparam int VOL_IO_W  = 7;
  localparam int ACT_W     = 2;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [LVL_W-1:0] FULL_LEVEL = LVL_W'(MAX_VOLUME) << FRAC_BITS;

  typedef enum logic [KIND_W-1:0] {
    KIND_PLAY   = 3'd0,
    KIND_FADE   = 3'd1,
    KIND_SETVOL = 3'd2,
    KIND_STOP   = 3'd3,
    KIND_PAUSE  = 3'd4,
    KIND_TICK   = 3'd5
  } kind_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_PLAY   = 2'd0,
    ACT_SETVOL = 2'd1,
    ACT_STOP   = 2'd2,
    ACT_PAUSE  = 2'd3
  } action_e;

  typedef struct packed {
    kind_e             kind;
    logic [CH_W-1:0]   chan;
    logic [TGT_W-1:0]  vol;
    logic [FR_W-1:0]   frames;
    logic              loop;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_wr_t;

  typedef struct packed {
    logic              start;
    logic [LVL_W-1:0]  mag;
    logic [FR_W-1:0]   divisor;
    logic              neg;
  } div_req_t;

  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic signed [STEP_W-1:0] quot;
  } div_rsp_t;

endpackage

/* hw/rtl/multichannel_volume_fader_top.sv */
// Top level of the multichannel volume fader.
// Commands arrive on the slave stream (kind in tuser) and pass a four-entry
// command queue; results leave on the master stream from an output register,
// with tlast on the final result of each command. Play, set volume, stop and
// pause are executed when the command is at the queue head and the output
// register is free; their result is loaded into the output register. A fade
// command runs a bit-serial divider for the step and holds the back end until
// the divider is done; it gives no result. A tick leaves the queue, then walks
// every channel in order: an idle channel gives no result and a fading channel
// gives up to three results; a stalled master stream holds the walk.
// The fader holds no memory that needs clearing: it takes commands right
// after reset. stop_after_fade_out is written through cfg_we_i and
// cfg_wdata_i and must only change while the block is idle.
module multichannel_volume_fader_top import mcvf_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [2:0] channel, [9:3] volume, [25:10] frames, [26] loop, [31:27] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [2:0] kind
  input  logic [KIND_W-1:0]      s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [2:0] channel_res, [9:3] volume_out, [10] loop_out, [15:11] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // [1:0] action
  output logic [ACT_W-1:0]       m_axis_tuser_o,
  output logic                   m_axis_tlast_o
);

  q_wr_t    q_wr;
  logic     q_full, q_empty, q_pop;
  cmd_t     q_cmd;
  div_req_t div_req;
  div_rsp_t div_rsp;

  mcvf_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_full_i        (q_full),
    .q_wr_o          (q_wr)
  );

  mcvf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .full_o  (q_full),
    .empty_o (q_empty),
    .pop_i   (q_pop),
    .cmd_o   (q_cmd)
  );

  mcvf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  mcvf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .q_empty_i       (q_empty),
    .q_cmd_i         (q_cmd),
    .q_pop_o         (q_pop),
    .div_req_o       (div_req),
    .div_rsp_i       (div_rsp),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

/* hw/rtl/mcvf_front.sv */
// Input side: accepts stream transactions, drops commands of unknown kind or channel, clamps and queues the rest.
module mcvf_front import mcvf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [2:0] channel, [9:3] volume, [25:10] frames, [26] loop
  input  logic [IN_TDATA_W-1:0] s_axis_tdata_i,
  // [2:0] kind
  input  logic [KIND_W-1:0]     s_axis_tuser_i,
  input  logic                  q_full_i,
  output q_wr_t                 q_wr_o
);

  logic [CHAN_IO_W-1:0] in_chan;
  logic [VOL_IO_W-1:0]  in_vol;
  logic [FR_W-1:0]      in_frames;
  logic                 chan_ok;
  logic                 keep;
  kind_e                kind;

  assign in_chan   = s_axis_tdata_i[2:0];
  assign in_vol    = s_axis_tdata_i[9:3];
  assign in_frames = s_axis_tdata_i[25:10];
  assign kind      = kind_e'(s_axis_tuser_i);
  assign chan_ok   = (32'(in_chan) < NUM_CHANNELS);

  assign s_axis_tready_o = !q_full_i;

  always_comb begin
    case (kind)
      KIND_PLAY, KIND_FADE, KIND_SETVOL, KIND_STOP, KIND_PAUSE: keep = chan_ok;
      KIND_TICK: keep = 1'b1;
      default: keep = 1'b0;
    endcase
  end

  always_comb begin
    q_wr_o.push       = s_axis_tvalid_i && !q_full_i && keep;
    q_wr_o.cmd.kind   = kind;
    q_wr_o.cmd.chan   = CH_W'(in_chan);
    q_wr_o.cmd.loop   = s_axis_tdata_i[26];
    q_wr_o.cmd.frames = (in_frames == '0) ? FR_W'(1) : in_frames;
    if (32'(in_vol) > MAX_VOLUME) begin
      q_wr_o.cmd.vol = TGT_W'(MAX_VOLUME);
    end else begin
      q_wr_o.cmd.vol = TGT_W'(in_vol);
    end
  end

  `include "assert_macros.svh"

  `MCVF_ASSERT_IMPL(a_push_needs_room, q_wr_o.push, s_axis_tready_o, "push into full queue")

endmodule

/* hw/rtl/mcvf_queue.sv */
// Short command queue between the front and the back of the fader.
module mcvf_queue import mcvf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  q_wr_t wr_i,
  output logic  full_o,
  output logic  empty_o,
  input  logic  pop_i,
  output cmd_t  cmd_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = (32'(count_q) == QUEUE_DEPTH);
  assign empty_o = (count_q == '0);
  assign do_push = wr_i.push && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_i.cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + (QPTR_W + 1)'(1);
        2'b01:   count_q <= count_q - (QPTR_W + 1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  `include "assert_macros.svh"

  `MCVF_ASSERT(a_count_bound, 32'(count_q) <= QUEUE_DEPTH, "queue count out of range")
  `MCVF_ASSERT_IMPL(a_ptr_gap, 1'b1, (wr_ptr_q - rd_ptr_q) == count_q[QPTR_W-1:0], "queue pointers disagree with count")

endmodule

/* hw/rtl/mcvf_div.sv */
// Restoring divider, one quotient bit per cycle, for the fade step.
module mcvf_div import mcvf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(LVL_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [FR_W-1:0]  rem_q, div_q, rem_d;
  logic [LVL_W-1:0] quo_q, quo_d;
  logic             neg_q;
  logic [FR_W:0]    shifted, trial;
  logic             ge;

  assign shifted = {rem_q, quo_q[LVL_W-1]};
  assign trial   = shifted - {1'b0, div_q};
  assign ge      = (shifted >= {1'b0, div_q});
  assign rem_d   = ge ? trial[FR_W-1:0] : shifted[FR_W-1:0];
  assign quo_d   = {quo_q[LVL_W-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(LVL_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.mag;
      div_q <= req_i.divisor;
      neg_q <= req_i.neg;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  always_comb begin
    rsp_o.busy = busy_q;
    rsp_o.done = done_q;
    if (neg_q) begin
      rsp_o.quot = -$signed({1'b0, quo_q});
    end else begin
      rsp_o.quot = $signed({1'b0, quo_q});
    end
  end

  `include "assert_macros.svh"

  `MCVF_ASSERT_IMPL(a_start_idle, req_i.start, !busy_q && !done_q, "divider restarted while busy")

endmodule

/* hw/rtl/mcvf_back.sv */
// Execution side: per-channel level state, tick walk, fade setup and result register.
module mcvf_back import mcvf_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i,
  input  logic                   q_empty_i,
  input  cmd_t                   q_cmd_i,
  output logic                   q_pop_o,
  output div_req_t               div_req_o,
  input  div_rsp_t               div_rsp_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic [ACT_W-1:0]       m_axis_tuser_o,
  output logic                   m_axis_tlast_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_WALK = 3'd2;
  localparam logic [2:0] S_SNAP = 3'd3;
  localparam logic [2:0] S_STOP = 3'd4;

  logic [2:0]               state_q, state_d;
  logic [CH_W-1:0]          idx_q, idx_d;
  logic                     down_q, down_d;
  logic                     stop_cfg_q;

  logic [LVL_W-1:0]         cur_q  [NUM_CHANNELS];
  logic [TGT_W-1:0]         tgt_q  [NUM_CHANNELS];
  logic signed [STEP_W-1:0] step_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]  fading_q;

  logic                     out_valid_q;
  logic [CHAN_IO_W-1:0]     out_chan_q, out_chan_d;
  action_e                  out_act_q, out_act_d;
  logic [VOL_IO_W-1:0]      out_vol_q, out_vol_d;
  logic                     out_loop_q, out_loop_d;
  logic                     out_last_q, out_last_d;
  logic                     out_load, out_free;

  logic [CH_W-1:0]          rd_idx;
  logic [LVL_W-1:0]         rd_cur, tgt_lvl, cur_new, cmd_lvl;
  logic [TGT_W-1:0]         rd_tgt;
  logic signed [STEP_W-1:0] rd_step;
  logic signed [LVL_W+1:0]  sum;
  logic [LVL_W:0]           diff;
  logic                     step_neg, done, higher;

  logic                     cur_we, tgt_we, step_we, fad_set, fad_clr;
  logic [LVL_W-1:0]         cur_wd;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign rd_idx   = (state_q == S_IDLE) ? q_cmd_i.chan : idx_q;
  assign rd_cur   = cur_q[rd_idx];
  assign rd_tgt   = tgt_q[rd_idx];
  assign rd_step  = step_q[rd_idx];
  assign tgt_lvl  = {rd_tgt, {FRAC_BITS{1'b0}}};
  assign cmd_lvl  = {q_cmd_i.vol, {FRAC_BITS{1'b0}}};
  assign step_neg = rd_step[STEP_W-1];

  // Step the level and saturate to the legal range.
  assign sum = $signed({2'b00, rd_cur}) + $signed({rd_step[STEP_W-1], rd_step});
  always_comb begin
    if (sum[LVL_W+1]) begin
      cur_new = '0;
    end else if (sum[LVL_W:0] > {1'b0, FULL_LEVEL}) begin
      cur_new = FULL_LEVEL;
    end else begin
      cur_new = sum[LVL_W-1:0];
    end
  end

  assign done = (rd_step == '0) || (!step_neg && cur_new >= tgt_lvl) ||
                (step_neg && cur_new <= tgt_lvl);

  // Any fading channel above the one being walked decides the last flag.
  always_comb begin
    higher = 1'b0;
    for (int j = 0; j < NUM_CHANNELS; j++) begin
      if (j > int'(idx_q)) begin
        higher = higher | fading_q[j];
      end
    end
  end

  assign diff = {1'b0, cmd_lvl} - {1'b0, rd_cur};

  always_comb begin
    div_req_o.divisor = q_cmd_i.frames;
    div_req_o.neg     = diff[LVL_W];
    div_req_o.mag     = diff[LVL_W] ? LVL_W'(-diff) : diff[LVL_W-1:0];
    div_req_o.start   = 1'b0;

    state_d    = state_q;
    idx_d      = idx_q;
    down_d     = down_q;
    q_pop_o    = 1'b0;
    out_load   = 1'b0;
    out_chan_d = 3'(rd_idx);
    out_act_d  = ACT_SETVOL;
    out_vol_d  = '0;
    out_loop_d = 1'b0;
    out_last_d = 1'b1;
    cur_we     = 1'b0;
    cur_wd     = cmd_lvl;
    tgt_we     = 1'b0;
    step_we    = 1'b0;
    fad_set    = 1'b0;
    fad_clr    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (!q_empty_i && out_free) begin
          q_pop_o = 1'b1;
          case (q_cmd_i.kind)
            KIND_PLAY: begin
              cur_we     = 1'b1;
              fad_clr    = 1'b1;
              out_load   = 1'b1;
              out_act_d  = ACT_PLAY;
              out_vol_d  = VOL_IO_W'(q_cmd_i.vol);
              out_loop_d = q_cmd_i.loop;
            end
            KIND_FADE: begin
              div_req_o.start = 1'b1;
              tgt_we          = 1'b1;
              idx_d           = q_cmd_i.chan;
              state_d         = S_DIV;
            end
            KIND_SETVOL: begin
              cur_we    = 1'b1;
              out_load  = 1'b1;
              out_act_d = ACT_SETVOL;
              out_vol_d = VOL_IO_W'(q_cmd_i.vol);
            end
            KIND_STOP: begin
              out_load  = 1'b1;
              out_act_d = ACT_STOP;
            end
            KIND_PAUSE: begin
              out_load  = 1'b1;
              out_act_d = ACT_PAUSE;
            end
            KIND_TICK: begin
              idx_d   = '0;
              state_d = S_WALK;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_rsp_i.done) begin
          step_we = 1'b1;
          fad_set = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_WALK, S_SNAP, S_STOP: begin
        if (state_q == S_WALK && !fading_q[idx_q]) begin
          state_d = S_IDLE;
          if (32'(idx_q) != NUM_CHANNELS - 1) begin
            idx_d   = idx_q + CH_W'(1);
            state_d = S_WALK;
          end
        end else if (out_free) begin
          out_load = 1'b1;
          if (state_q == S_WALK) begin
            cur_we     = 1'b1;
            cur_wd     = cur_new;
            down_d     = step_neg;
            out_vol_d  = VOL_IO_W'(cur_new[LVL_W-1:FRAC_BITS]);
            out_last_d = !done && !higher;
          end else if (state_q == S_SNAP) begin
            cur_we     = 1'b1;
            cur_wd     = tgt_lvl;
            fad_clr    = 1'b1;
            out_vol_d  = VOL_IO_W'(rd_tgt);
            out_last_d = !(down_q && stop_cfg_q) && !higher;
          end else begin
            out_act_d  = ACT_STOP;
            out_last_d = !higher;
          end
          // Pick the next step of the walk.
          if (state_q == S_WALK && done) begin
            state_d = S_SNAP;
          end else if (state_q == S_SNAP && down_q && stop_cfg_q) begin
            state_d = S_STOP;
          end else if (32'(idx_q) == NUM_CHANNELS - 1) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + CH_W'(1);
            state_d = S_WALK;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      down_q      <= 1'b0;
      stop_cfg_q  <= 1'b1;
      out_valid_q <= 1'b0;
      fading_q    <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        cur_q[i]  <= FULL_LEVEL;
        tgt_q[i]  <= TGT_W'(MAX_VOLUME);
        step_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      down_q  <= down_d;
      if (cfg_we_i) begin
        stop_cfg_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cur_we) begin
        cur_q[rd_idx] <= cur_wd;
      end
      if (tgt_we) begin
        tgt_q[rd_idx] <= q_cmd_i.vol;
      end
      if (step_we) begin
        step_q[rd_idx] <= div_rsp_i.quot;
      end
      if (fad_set) begin
        fading_q[rd_idx] <= 1'b1;
      end else if (fad_clr) begin
        fading_q[rd_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_chan_q <= out_chan_d;
      out_act_q  <= out_act_d;
      out_vol_q  <= out_vol_d;
      out_loop_q <= out_loop_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W - 11){1'b0}}, out_loop_q, out_vol_q, out_chan_q};
  assign m_axis_tuser_o  = out_act_q;
  assign m_axis_tlast_o  = out_last_q;

  `include "assert_macros.svh"

  `MCVF_ASSERT_IMPL(a_no_overwrite, out_valid_q && !m_axis_tready_i, !out_load, "result overwritten while stalled")
  `MCVF_ASSERT_IMPL(a_div_done_state, div_rsp_i.done, state_q == S_DIV, "divider result outside fade setup")
  `MCVF_ASSERT_IMPL(a_snap_fading, state_q == S_SNAP, fading_q[idx_q], "snap on a channel that is not fading")

endmodule
